// ===== design/cam_window_sync_decoder_core_assert.svh =====
// Assertion macros for the cam window sync decoder core.
`ifndef CAM_WINDOW_SYNC_DECODER_CORE_ASSERT_SVH
`define CAM_WINDOW_SYNC_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CWSD_ASSERT_NOW(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (expr)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CWSD_ASSERT_NEXT(label, cond, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

// ===== design/cwsd_pkg.sv =====
// Types and constants of the cam window sync decoder.
package cwsd_pkg;

	localparam int NUM_EVENTS  = 16;
	localparam int EV_W        = $clog2(NUM_EVENTS);
	localparam int ANGLE_SCALE = 50;

	localparam int unsigned DIVISOR     = 90 * ANGLE_SCALE;
	localparam int          RECIP_SHIFT = 31 + $clog2(DIVISOR);
	localparam logic [63:0] RECIP_FULL  = (64'd1 << RECIP_SHIFT) / 64'(DIVISOR);
	localparam logic [31:0] RECIP       = RECIP_FULL[31:0];

	localparam logic [7:0] EXPECTED_COUNTS [NUM_EVENTS] = '{
		8'd4, 8'd86, 8'd44, 8'd46, 8'd4, 8'd86, 8'd14, 8'd76,
		8'd4, 8'd86, 8'd24, 8'd66, 8'd4, 8'd86, 8'd34, 8'd56
	};

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_AMBIGUOUS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOOTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_CUM     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ERODE       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER  = 3'd4;

	localparam logic [7:0]  RST_AMBIGUOUS  = 8'd86;
	localparam logic [6:0]  RST_MAX_TOOTH  = 7'd5;
	localparam logic [6:0]  RST_MAX_CUM    = 7'd10;
	localparam logic [15:0] RST_ERODE      = 16'd8;
	localparam logic [15:0] RST_MULTIPLIER = 16'd1;
	localparam logic [7:0]  RST_READING    = 8'hFF;

	typedef enum logic [1:0] {
		LOSS_NONE  = 2'd0,
		LOSS_TOOTH = 2'd1,
		LOSS_CUM   = 2'd2
	} loss_t;

	typedef struct packed {
		logic            synced;
		logic [EV_W-1:0] event_index;
		logic [7:0]      tooth_error;
		logic [7:0]      cumulative_error;
		loss_t           loss_kind;
		logic            calc_request;
	} res_t;

endpackage

// ===== design/cam_window_sync_decoder_core.sv =====
// Cam window sync decoder: sync search, tooth error tracking, ticks per degree.
// Throughput: one edge per cycle until a stalled output backs up the stages.
// The sync state updates in one pass as a beat leaves the input register, and
// ticks per degree follows in a multiply pipeline of stages s2 to s5.
// Reset: asynchronous, clears sync, errors and counters, loads register defaults.
// Stages advance independently, so bubbles close up while the output is stalled.
`include "cam_window_sync_decoder_core_assert.svh"

module cam_window_sync_decoder_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [cwsd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [15:0]                       cfg_data,
	input  logic                              edge_valid,
	output logic                              edge_stall,
	input  logic [7:0]                        accumulator_reading,
	input  logic [15:0]                       edge_time,
	input  logic                              overflow_pending,
	input  logic [15:0]                       time_extension,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              synced,
	output logic [cwsd_pkg::EV_W-1:0]         event_index,
	output logic signed [7:0]                 tooth_error,
	output logic signed [7:0]                 cumulative_error,
	output logic [1:0]                        loss_kind,
	output logic                              calc_request,
	output logic [15:0]                       ticks_per_degree
);

	// configuration
	logic [7:0]  ambiguous_q;
	logic [6:0]  max_tooth_q;
	logic [6:0]  max_cum_q;
	logic [15:0] erode_period_q;
	logic [15:0] multiplier_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ambiguous_q    <= cwsd_pkg::RST_AMBIGUOUS;
			max_tooth_q    <= cwsd_pkg::RST_MAX_TOOTH;
			max_cum_q      <= cwsd_pkg::RST_MAX_CUM;
			erode_period_q <= cwsd_pkg::RST_ERODE;
			multiplier_q   <= cwsd_pkg::RST_MULTIPLIER;
		end else if (cfg_write) begin
			case (cfg_index)
				cwsd_pkg::CFG_AMBIGUOUS:  ambiguous_q    <= cfg_data[7:0];
				cwsd_pkg::CFG_MAX_TOOTH:  max_tooth_q    <= cfg_data[6:0];
				cwsd_pkg::CFG_MAX_CUM:    max_cum_q      <= cfg_data[6:0];
				cwsd_pkg::CFG_ERODE:      erode_period_q <= cfg_data;
				cwsd_pkg::CFG_MULTIPLIER: multiplier_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	assign rdy5 = !v_s5 || !result_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign edge_stall = !rdy1;

	logic advance1;
	assign advance1 = v_s1 && rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= edge_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
		end
	end

	// input register
	logic [7:0]  reading_s1;
	logic [15:0] etime_s1;
	logic        ovf_s1;
	logic [15:0] ext_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && edge_valid) begin
			reading_s1 <= accumulator_reading;
			etime_s1   <= edge_time;
			ovf_s1     <= overflow_pending;
			ext_s1     <= time_extension;
		end
	end

	// decoder state
	logic                      sync_q;
	logic [cwsd_pkg::EV_W-1:0] event_q;
	logic [7:0]                prev_reading_q;
	logic [7:0]                prev_count_q;
	logic [7:0]                running_q;
	logic [15:0]               erode_q;
	logic [31:0]               last_stamp_q;

	logic                      sync_n;
	logic [cwsd_pkg::EV_W-1:0] event_n;
	logic [7:0]                prev_count_n;
	logic [7:0]                running_n;
	logic [15:0]               erode_n;
	logic [31:0]               last_stamp_n;
	cwsd_pkg::res_t            res_n;
	logic [31:0]               period_n;

	always_comb begin
		logic [7:0]                count;
		logic                      found;
		logic [cwsd_pkg::EV_W-1:0] match_idx;
		logic [cwsd_pkg::EV_W-1:0] prev_ev;
		logic [7:0]                terr;
		logic [7:0]                sum;
		logic [15:0]               erode_inc;
		logic signed [8:0]         te9;
		logic signed [8:0]         rc9;
		logic signed [8:0]         tooth_lim;
		logic signed [8:0]         cum_lim;
		logic [15:0]               hi;
		logic [31:0]               stamp;

		count     = reading_s1 - prev_reading_q;
		found     = 1'b0;
		match_idx = '0;
		for (int i = cwsd_pkg::NUM_EVENTS - 1; i >= 0; i--) begin
			if (cwsd_pkg::EXPECTED_COUNTS[i] == count) begin
				found     = 1'b1;
				match_idx = cwsd_pkg::EV_W'(i);
			end
		end
		prev_ev = match_idx - 1'b1;

		sync_n       = sync_q;
		event_n      = event_q;
		prev_count_n = prev_count_q;
		running_n    = running_q;
		erode_n      = erode_q;
		last_stamp_n = last_stamp_q;
		period_n     = '0;
		terr         = '0;
		sum          = '0;
		erode_inc    = '0;
		te9          = '0;
		rc9          = '0;
		hi           = '0;
		stamp        = '0;
		tooth_lim    = signed'({2'b00, max_tooth_q});
		cum_lim      = signed'({2'b00, max_cum_q});

		res_n.loss_kind    = cwsd_pkg::LOSS_NONE;
		res_n.calc_request = 1'b0;

		// search
		if (!sync_q && count != ambiguous_q && found) begin
			event_n      = prev_ev;
			prev_count_n = count;
			if (cwsd_pkg::EXPECTED_COUNTS[prev_ev] == prev_count_q) sync_n = 1'b1;
		end

		res_n.cumulative_error = running_q;

		if (sync_n) begin
			event_n = event_n + 1'b1;
			terr    = count - cwsd_pkg::EXPECTED_COUNTS[event_n];
			sum     = running_q + terr;
			if (erode_period_q != '0) begin
				erode_inc = erode_q + 1'b1;
				if (erode_inc == erode_period_q) begin
					erode_n = '0;
					if (!sum[7] && sum != '0) begin
						sum = sum - 1'b1;
					end else if (sum[7]) begin
						sum = sum + 1'b1;
					end
				end else begin
					erode_n = erode_inc;
				end
			end
			running_n              = sum;
			res_n.cumulative_error = sum;
			te9 = signed'({terr[7], terr});
			rc9 = signed'({sum[7], sum});
			if (te9 > tooth_lim || te9 < -tooth_lim) begin
				res_n.loss_kind = cwsd_pkg::LOSS_TOOTH;
			end else if (rc9 > cum_lim || rc9 < -cum_lim) begin
				res_n.loss_kind = cwsd_pkg::LOSS_CUM;
			end
			if (res_n.loss_kind != cwsd_pkg::LOSS_NONE) begin
				sync_n    = 1'b0;
				running_n = '0;
				erode_n   = '0;
			end else if (event_n[0]) begin
				hi = ext_s1;
				if (ovf_s1 && !etime_s1[15]) hi = hi + 1'b1;
				stamp              = {hi, etime_s1};
				period_n           = stamp - last_stamp_q;
				last_stamp_n       = stamp;
				res_n.calc_request = 1'b1;
			end
		end

		res_n.synced      = sync_n;
		res_n.event_index = event_n;
		res_n.tooth_error = terr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q         <= 1'b0;
			event_q        <= '0;
			prev_reading_q <= cwsd_pkg::RST_READING;
			prev_count_q   <= cwsd_pkg::RST_READING;
			running_q      <= '0;
			erode_q        <= '0;
			last_stamp_q   <= '0;
		end else if (advance1) begin
			sync_q         <= sync_n;
			event_q        <= event_n;
			prev_reading_q <= reading_s1;
			prev_count_q   <= prev_count_n;
			running_q      <= running_n;
			erode_q        <= erode_n;
			last_stamp_q   <= last_stamp_n;
		end
	end

	// ticks per degree pipeline
	cwsd_pkg::res_t res_s2, res_s3, res_s4, res_s5;
	logic [15:0]    mult_s2;
	logic [31:0]    period_s2;
	logic [31:0]    prod_s3;
	logic [31:0]    prod_s4;
	logic [31:0]    quot_s4;
	logic [15:0]    tpd_s5;

	logic [63:0] recip_prod;
	logic [63:0] quot_full;
	logic [31:0] remainder;
	logic [31:0] quot_fixed;

	assign recip_prod = {32'd0, prod_s3} * {32'd0, cwsd_pkg::RECIP};
	assign quot_full  = recip_prod >> cwsd_pkg::RECIP_SHIFT;
	assign remainder  = prod_s4 - 32'(quot_s4 * cwsd_pkg::DIVISOR);
	assign quot_fixed = (remainder >= 32'(cwsd_pkg::DIVISOR)) ? quot_s4 + 1'b1 : quot_s4;

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			res_s2    <= res_n;
			mult_s2   <= res_n.calc_request ? multiplier_q : 16'd0;
			period_s2 <= period_n;
		end
		if (rdy3 && v_s2) begin
			res_s3  <= res_s2;
			prod_s3 <= 32'({16'd0, mult_s2} * period_s2);
		end
		if (rdy4 && v_s3) begin
			res_s4  <= res_s3;
			prod_s4 <= prod_s3;
			quot_s4 <= quot_full[31:0];
		end
		if (rdy5 && v_s4) begin
			res_s5 <= res_s4;
			tpd_s5 <= quot_fixed[15:0];
		end
	end

	assign result_valid     = v_s5;
	assign synced           = res_s5.synced;
	assign event_index      = res_s5.event_index;
	assign tooth_error      = signed'(res_s5.tooth_error);
	assign cumulative_error = signed'(res_s5.cumulative_error);
	assign loss_kind        = res_s5.loss_kind;
	assign calc_request     = res_s5.calc_request;
	assign ticks_per_degree = tpd_s5;

	`CWSD_ASSERT_NOW(a_loss_drops_sync, result_valid && loss_kind != cwsd_pkg::LOSS_NONE, !synced, "sync held after a loss")
	`CWSD_ASSERT_NOW(a_calc_on_odd_sync, result_valid && calc_request, synced && event_index[0] && loss_kind == cwsd_pkg::LOSS_NONE, "speed figure outside an odd synced event")
	`CWSD_ASSERT_NOW(a_tpd_zero_idle, result_valid && !calc_request, ticks_per_degree == 16'd0, "ticks per degree without a request")
	`CWSD_ASSERT_NEXT(a_unsynced_clear, !sync_n && advance1, running_q == 8'd0 && erode_q == 16'd0, "error state left after sync loss")

endmodule
